[rtl/pgd_pkg.sv]
// ----------------------------------------------------------------------------
// pgd_pkg
// Shared types and constants of the proximity gesture dimmer: gesture modes,
// micro-operations, jump conditions, control and status words, register map.
// ----------------------------------------------------------------------------
package pgd_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 16;
    localparam int LEVEL_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 3;
    localparam int CNT_W      = 4;
    localparam int AVG_SHIFT  = 3;

    localparam logic [SAMPLE_W-1:0] INVALID_SAMPLE = 8'd255;
    localparam logic [LEVEL_W-1:0]  FULL_LEVEL     = 10'd1000;
    localparam logic [CNT_W-1:0]    DIV_LAST       = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MARGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADJ_LIMIT   = 3'd4;

    localparam logic [SAMPLE_W-1:0] RST_RANGE_MIN   = 8'd10;
    localparam logic [SAMPLE_W-1:0] RST_RANGE_MAX   = 8'd100;
    localparam logic [SAMPLE_W-1:0] RST_NEAR_MARGIN = 8'd5;
    localparam logic [LIMIT_W-1:0]  RST_TAP_LIMIT   = 16'd1000;
    localparam logic [LIMIT_W-1:0]  RST_ADJ_LIMIT   = 16'd3000;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_HAND   = 3'd1,
        MODE_ADJUST = 3'd2,
        MODE_ACK    = 3'd3,
        MODE_WAIT   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        UOP_FETCH,
        UOP_AVG,
        UOP_NEAR,
        UOP_MODE,
        UOP_CLAMP,
        UOP_MUL,
        UOP_DIV,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_ITEM,
        COND_NO_LEVEL,
        COND_FLAT,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic level_req;
        logic flat;
        logic div_more;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] range_min;
        logic [SAMPLE_W-1:0] range_max;
        logic [SAMPLE_W-1:0] near_margin;
        logic [LIMIT_W-1:0]  tap_limit_ms;
        logic [LIMIT_W-1:0]  adjust_limit_ms;
    } cfg_t;

endpackage

[rtl/pgd_seq.sv]
// ----------------------------------------------------------------------------
// pgd_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module pgd_seq
    import pgd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  s_ready
);

    localparam step_t STEP_FETCH = 3'd0;
    localparam step_t STEP_AVG   = 3'd1;
    localparam step_t STEP_NEAR  = 3'd2;
    localparam step_t STEP_MODE  = 3'd3;
    localparam step_t STEP_CLAMP = 3'd4;
    localparam step_t STEP_MUL   = 3'd5;
    localparam step_t STEP_DIV   = 3'd6;
    localparam step_t STEP_EMIT  = 3'd7;

    step_t step_reg;
    step_t step_next;
    logic  take;

    // control store
    always_comb begin
        case (step_reg)
            STEP_FETCH: ctrl = '{uop: UOP_FETCH, cond: COND_NO_ITEM,  target: STEP_FETCH};
            STEP_AVG:   ctrl = '{uop: UOP_AVG,   cond: COND_NEVER,    target: STEP_FETCH};
            STEP_NEAR:  ctrl = '{uop: UOP_NEAR,  cond: COND_NEVER,    target: STEP_FETCH};
            STEP_MODE:  ctrl = '{uop: UOP_MODE,  cond: COND_NO_LEVEL, target: STEP_EMIT};
            STEP_CLAMP: ctrl = '{uop: UOP_CLAMP, cond: COND_NEVER,    target: STEP_FETCH};
            STEP_MUL:   ctrl = '{uop: UOP_MUL,   cond: COND_FLAT,     target: STEP_EMIT};
            STEP_DIV:   ctrl = '{uop: UOP_DIV,   cond: COND_DIV_MORE, target: STEP_DIV};
            STEP_EMIT:  ctrl = '{uop: UOP_EMIT,  cond: COND_OUT_BUSY, target: STEP_EMIT};
            default:    ctrl = '{uop: UOP_FETCH, cond: COND_NEVER,    target: STEP_FETCH};
        endcase
    end

    always_comb begin
        case (ctrl.cond)
            COND_NEVER:    take = 1'b0;
            COND_NO_ITEM:  take = !s_valid;
            COND_NO_LEVEL: take = !stat.level_req;
            COND_FLAT:     take = stat.flat;
            COND_DIV_MORE: take = stat.div_more;
            COND_OUT_BUSY: take = stat.out_busy;
            default:       take = 1'b0;
        endcase
    end

    // last step wraps back to fetch
    assign step_next = take ? ctrl.target : step_reg + step_t'(1);
    assign s_ready   = (ctrl.uop == UOP_FETCH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

[rtl/pgd_datapath.sv]
// ----------------------------------------------------------------------------
// pgd_datapath
// Datapath driven by the control word: moving average, near test, gesture
// mode machine, window clamp, level multiply, restoring divider, result item.
// ----------------------------------------------------------------------------
module pgd_datapath
    import pgd_pkg::*;
#(
    parameter int AVG_FRAC_BITS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ctrl_t                             ctrl,
    input  cfg_t                              cfg,
    input  logic                              s_valid,
    input  logic [SAMPLE_W-1:0]               s_range_sample,
    input  logic [TIME_W-1:0]                 s_now_ms,
    input  logic                              m_ready,
    output stat_t                             stat,
    output logic                              m_valid,
    output logic [2:0]                        m_mode,
    output logic                              m_hand_near,
    output logic                              m_toggle_pulse,
    output logic                              m_level_valid,
    output logic [LEVEL_W-1:0]                m_level_permille,
    output logic [SAMPLE_W+AVG_FRAC_BITS-1:0] m_average_q4
);

    localparam int AVG_W = SAMPLE_W + AVG_FRAC_BITS;
    localparam int SUM_W = AVG_W + AVG_SHIFT;
    localparam int THR_W = AVG_W + 1;
    localparam int NUM_W = AVG_W + LEVEL_W;

    // gesture state
    mode_t             mode_reg;
    mode_t             mode_next;
    logic [AVG_W-1:0]  avg_reg;
    logic [TIME_W-1:0] hand_start_reg;
    logic [TIME_W-1:0] hold_reg;

    // item scratch
    logic [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                near_reg;
    logic [TIME_W-1:0]   diff_reg;
    logic                toggle_reg;
    logic                level_reg;
    logic                flat_reg;
    logic [AVG_W-1:0]    den_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    den_sh_reg;
    logic [LEVEL_W-1:0]  quot_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // result item
    logic                m_valid_reg;
    logic [2:0]          m_mode_reg;
    logic                m_near_reg;
    logic                m_toggle_reg;
    logic                m_lvalid_reg;
    logic [LEVEL_W-1:0]  m_level_reg;
    logic [AVG_W-1:0]    m_avg_reg;

    logic [SUM_W-1:0]  avg_x;
    logic [SUM_W-1:0]  avg_sum;
    logic [AVG_W-1:0]  avg_new;
    logic [THR_W-1:0]  near_thr;
    logic              near_c;
    logic [AVG_W-1:0]  maxq;
    logic [AVG_W-1:0]  minq;
    logic [AVG_W-1:0]  avg_hi;
    logic [AVG_W-1:0]  avg_cl;
    logic [NUM_W-1:0]  num_c;
    logic              div_ge;
    logic              diff_gt_tap;
    logic              diff_lt_adj;
    logic              hold_lt_tap;
    logic              toggle_c;
    logic              level_c;
    logic              start_ld;
    logic              hold_ld;
    logic [TIME_W-1:0] hold_val;
    logic              out_busy;
    logic              out_load;

    // 7/8 average
    assign avg_x   = SUM_W'(avg_reg);
    assign avg_sum = (avg_x << AVG_SHIFT) - avg_x + (SUM_W'(sample_reg) << AVG_FRAC_BITS);
    assign avg_new = AVG_W'(avg_sum >> AVG_SHIFT);

    // near test
    assign near_thr = (THR_W'(cfg.range_max) + THR_W'(cfg.near_margin)) << AVG_FRAC_BITS;
    assign near_c   = (sample_reg != INVALID_SAMPLE) && (THR_W'(avg_reg) < near_thr);

    // window clamp
    assign maxq   = AVG_W'(cfg.range_max) << AVG_FRAC_BITS;
    assign minq   = AVG_W'(cfg.range_min) << AVG_FRAC_BITS;
    assign avg_hi = (avg_reg > maxq) ? maxq : avg_reg;
    assign avg_cl = (avg_hi < minq) ? minq : avg_hi;

    assign num_c  = NUM_W'(FULL_LEVEL) * NUM_W'(maxq - avg_reg);
    assign div_ge = (rem_reg >= den_sh_reg);

    assign diff_gt_tap = diff_reg > TIME_W'(cfg.tap_limit_ms);
    assign diff_lt_adj = diff_reg < TIME_W'(cfg.adjust_limit_ms);
    assign hold_lt_tap = hold_reg < TIME_W'(cfg.tap_limit_ms);

    // mode next state
    always_comb begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_IDLE: begin
                if (near_reg) begin
                    mode_next = MODE_HAND;
                end
            end
            MODE_HAND: begin
                if (near_reg) begin
                    if (diff_gt_tap) begin
                        mode_next = MODE_ADJUST;
                    end
                end else if (hold_lt_tap) begin
                    mode_next = MODE_ACK;
                end
            end
            MODE_ADJUST: begin
                if (near_reg) begin
                    if (!diff_lt_adj) begin
                        mode_next = MODE_WAIT;
                    end
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_ACK: begin
                mode_next = MODE_IDLE;
            end
            MODE_WAIT: begin
                if (!near_reg) begin
                    mode_next = MODE_ACK;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // mode outputs
    always_comb begin
        toggle_c = 1'b0;
        level_c  = 1'b0;
        start_ld = 1'b0;
        hold_ld  = 1'b0;
        hold_val = diff_reg;
        case (mode_reg)
            MODE_IDLE: begin
                if (near_reg) begin
                    start_ld = 1'b1;
                    hold_ld  = 1'b1;
                    hold_val = '0;
                end
            end
            MODE_HAND: begin
                if (near_reg) begin
                    hold_ld  = 1'b1;
                    start_ld = diff_gt_tap;
                end else begin
                    toggle_c = hold_lt_tap;
                end
            end
            MODE_ADJUST: begin
                if (near_reg) begin
                    hold_ld = 1'b1;
                    level_c = diff_lt_adj;
                end
            end
            MODE_WAIT: begin
                if (!near_reg) begin
                    hold_ld  = 1'b1;
                    hold_val = now_reg;
                end
            end
            default: begin
                toggle_c = 1'b0;
            end
        endcase
    end

    assign out_busy = m_valid_reg && !m_ready;
    assign out_load = (ctrl.uop == UOP_EMIT) && !out_busy;

    assign stat.level_req = level_c;
    assign stat.flat      = flat_reg;
    assign stat.div_more  = (cnt_reg != '0);
    assign stat.out_busy  = out_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            avg_reg        <= '0;
            hand_start_reg <= '0;
            hold_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (ctrl.uop == UOP_AVG) begin
                avg_reg <= avg_new;
            end
            if (ctrl.uop == UOP_CLAMP) begin
                avg_reg <= avg_cl;
            end
            if (ctrl.uop == UOP_MODE) begin
                mode_reg <= mode_next;
                if (start_ld) begin
                    hand_start_reg <= now_reg;
                end
                if (hold_ld) begin
                    hold_reg <= hold_val;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.uop)
            UOP_FETCH: begin
                if (s_valid) begin
                    sample_reg <= s_range_sample;
                    now_reg    <= s_now_ms;
                end
            end
            UOP_NEAR: begin
                near_reg <= near_c;
                diff_reg <= now_reg - hand_start_reg;
            end
            UOP_MODE: begin
                toggle_reg <= toggle_c;
                level_reg  <= level_c;
            end
            UOP_CLAMP: begin
                flat_reg <= (cfg.range_max <= cfg.range_min);
                den_reg  <= maxq - minq;
            end
            UOP_MUL: begin
                rem_reg    <= num_c;
                den_sh_reg <= NUM_W'(den_reg) << DIV_LAST;
                cnt_reg    <= DIV_LAST;
                quot_reg   <= flat_reg ? FULL_LEVEL : '0;
            end
            UOP_DIV: begin
                if (div_ge) begin
                    rem_reg <= rem_reg - den_sh_reg;
                end
                quot_reg   <= {quot_reg[LEVEL_W-2:0], div_ge};
                den_sh_reg <= den_sh_reg >> 1;
                cnt_reg    <= cnt_reg - CNT_W'(1);
            end
            UOP_EMIT: begin
                if (out_load) begin
                    m_mode_reg   <= mode_reg;
                    m_near_reg   <= near_reg;
                    m_toggle_reg <= toggle_reg;
                    m_lvalid_reg <= level_reg;
                    m_level_reg  <= level_reg ? quot_reg : '0;
                    m_avg_reg    <= avg_reg;
                end
            end
            default: begin
                near_reg <= near_reg;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_mode           = m_mode_reg;
    assign m_hand_near      = m_near_reg;
    assign m_toggle_pulse   = m_toggle_reg;
    assign m_level_valid    = m_lvalid_reg;
    assign m_level_permille = m_level_reg;
    assign m_average_q4     = m_avg_reg;

endmodule

[rtl/proximity_gesture_dimmer.sv]
// ----------------------------------------------------------------------------
// proximity_gesture_dimmer
// Hand gesture switch and dimmer on a range sensor: moving average, near
// detection, tap toggle and long-hold brightness adjust in permille.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_range_sample, s_now_ms
//  m_        out        m_valid / m_ready    m_mode, m_hand_near, m_toggle_pulse,
//                                            m_level_valid, m_level_permille,
//                                            m_average_q4
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one item at a time through an 8-step microprogram: a new item is fetched
//  only after emit; without a level the mode step jumps to emit, an empty
//  window jumps from multiply to emit, a level runs the restoring divider
//  a full output register holds the emit step until m_ready; s_ready is high
//  only on the fetch step, which can overlap a result still waiting
//  synchronous active-low reset clears mode, average, timers and valid flags
// ----------------------------------------------------------------------------
module proximity_gesture_dimmer
    import pgd_pkg::*;
#(
    parameter int AVG_FRAC_BITS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [SAMPLE_W-1:0]               s_range_sample,
    input  logic [TIME_W-1:0]                 s_now_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_mode,
    output logic                              m_hand_near,
    output logic                              m_toggle_pulse,
    output logic                              m_level_valid,
    output logic [LEVEL_W-1:0]                m_level_permille,
    output logic [SAMPLE_W+AVG_FRAC_BITS-1:0] m_average_q4,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]             cfg_data
);

    logic [SAMPLE_W-1:0] range_min_reg;
    logic [SAMPLE_W-1:0] range_max_reg;
    logic [SAMPLE_W-1:0] near_margin_reg;
    logic [LIMIT_W-1:0]  tap_limit_reg;
    logic [LIMIT_W-1:0]  adj_limit_reg;
    cfg_t                cfg;
    ctrl_t               ctrl;
    stat_t               stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_min_reg   <= RST_RANGE_MIN;
            range_max_reg   <= RST_RANGE_MAX;
            near_margin_reg <= RST_NEAR_MARGIN;
            tap_limit_reg   <= RST_TAP_LIMIT;
            adj_limit_reg   <= RST_ADJ_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RANGE_MIN:   range_min_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_RANGE_MAX:   range_max_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_NEAR_MARGIN: near_margin_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_TAP_LIMIT:   tap_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_ADJ_LIMIT:   adj_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default: begin
                    range_min_reg <= range_min_reg;
                end
            endcase
        end
    end

    assign cfg.range_min       = range_min_reg;
    assign cfg.range_max       = range_max_reg;
    assign cfg.near_margin     = near_margin_reg;
    assign cfg.tap_limit_ms    = tap_limit_reg;
    assign cfg.adjust_limit_ms = adj_limit_reg;

    pgd_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .ctrl    (ctrl),
        .s_ready (s_ready)
    );

    pgd_datapath #(
        .AVG_FRAC_BITS (AVG_FRAC_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .cfg              (cfg),
        .s_valid          (s_valid),
        .s_range_sample   (s_range_sample),
        .s_now_ms         (s_now_ms),
        .m_ready          (m_ready),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_mode           (m_mode),
        .m_hand_near      (m_hand_near),
        .m_toggle_pulse   (m_toggle_pulse),
        .m_level_valid    (m_level_valid),
        .m_level_permille (m_level_permille),
        .m_average_q4     (m_average_q4)
    );

    // a level only comes out of adjust mode and never exceeds full scale
    a_level_in_adjust: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_level_valid) |->
            (m_mode == 3'(MODE_ADJUST)) && (m_level_permille <= FULL_LEVEL))
        else $error("level item outside adjust mode or above full scale");

    // a toggle always lands in acknowledge without a level
    a_toggle_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_toggle_pulse) |-> (m_mode == 3'(MODE_ACK)) && !m_level_valid)
        else $error("toggle item not in acknowledge mode");

    // no level item carries a nonzero level
    a_level_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_level_valid) |-> (m_level_permille == '0))
        else $error("level field nonzero without level_valid");

    // after an item is taken the program leaves the fetch step
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while one is in progress");

endmodule
